// File: src/cpr_pkg.sv
package cpr_pkg;

    localparam int PORT_COUNT  = 4;
    localparam int DATA_BLOCKS = 1024;
    localparam int BLOCK_BYTES = 32;

    localparam int WORD_W  = 64;
    localparam int BLOCK_W = BLOCK_BYTES * 8;

    // save store: one row holds a whole block, port-major
    localparam int ROWS   = PORT_COUNT * DATA_BLOCKS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ECHO_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    localparam logic [10:0] ECHO_BLOCK   = 11'h400;
    localparam logic [10:0] RUMBLE_BLOCK = 11'h600;

    localparam logic [7:0] CRC_POLY = 8'h85;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // 32 data bytes plus one appended zero byte
    localparam int CRC_STEPS = BLOCK_BYTES + 1;
    localparam int CRC_CNT_W = $clog2(CRC_STEPS);

    localparam int CMD_DEPTH = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_STORE,
        TGT_ECHO,
        TGT_RUMBLE
    } target_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACCESS,
        BK_CRC,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic               write_op;
        logic [1:0]         port;
        target_t            target;
        logic [ROW_W-1:0]   row;
        logic               rumble_on;
        logic [BLOCK_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         port;
        logic [BLOCK_W-1:0] rdata;
        logic [7:0]         crc;
        logic               rumble_update;
        logic               rumble_on;
    } result_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // eight MSB-first shifts of the CRC register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
        logic [7:0] r;
        logic       fb;
        r = crc_in;
        for (int b = 7; b >= 0; b--)
        begin
            fb = ((r & CRC_TOP) != 8'h00);
            r  = {r[6:0], din[b]} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

endpackage

// File: src/cpr_crc8.sv
module cpr_crc8 import cpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BLOCK_W-1:0] data,
    output logic               done,
    output logic [7:0]         crc
);

    logic [BLOCK_W-1:0]   sh_reg;
    logic [7:0]           crc_reg;
    logic [CRC_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic last_step;
    assign last_step = run_reg && (cnt_reg == CRC_CNT_W'(CRC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    run_reg <= 1'b0;
            end
        end
    end

    // one byte per cycle; zeros shift in, so the last step feeds the zero tail
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= data;
            crc_reg <= 8'h00;
        end
        else if (run_reg)
        begin
            sh_reg  <= {sh_reg[BLOCK_W-9:0], 8'h00};
            crc_reg <= crc8_byte(crc_reg, sh_reg[BLOCK_W-1 -: 8]);
        end
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

// File: src/cpr_front.sv
module cpr_front import cpr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic         opcode,
    input  logic [1:0]   port,
    input  logic [15:0]  pak_address,
    input  logic [63:0]  write_data_0,
    input  logic [63:0]  write_data_1,
    input  logic [63:0]  write_data_2,
    input  logic [63:0]  write_data_3,
    input  back_status_t status,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output cmd_t         cmd
);

    cmd_t       q_reg [CMD_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic        accept, deq;
    logic        write_op, port_ok;
    logic [10:0] blk;
    logic [12:0] row_full;
    cmd_t        new_cmd;

    // classify
    always_comb
    begin
        write_op = (opcode == OP_WRITE);
        blk      = pak_address[15:5];
        port_ok  = (3'(port) < 3'(PORT_COUNT));
        row_full = 13'(port) * 13'(DATA_BLOCKS) + 13'(blk);

        new_cmd.write_op  = write_op;
        new_cmd.port      = port;
        new_cmd.row       = row_full[ROW_W-1:0];
        new_cmd.data      = write_op ? {write_data_0, write_data_1, write_data_2, write_data_3}
                                     : '0;
        new_cmd.rumble_on = 1'b0;
        new_cmd.target    = TGT_NONE;
        if (port_ok)
        begin
            if (blk == ECHO_BLOCK)
                new_cmd.target = TGT_ECHO;
            else if (blk < 11'(DATA_BLOCKS))
                new_cmd.target = TGT_STORE;
            else if (blk == RUMBLE_BLOCK && write_op)
            begin
                new_cmd.target    = TGT_RUMBLE;
                new_cmd.rumble_on = (write_data_0[63:56] != 8'h00);
            end
        end
    end

    assign full      = (cnt_reg == 2'(CMD_DEPTH)) || status.clearing;
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign deq       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(accept) - 2'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= new_cmd;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(CMD_DEPTH))
        else $error("command queue overfilled");

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !accept)
        else $error("beat taken during store clear");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

// File: src/cpr_back.sv
module cpr_back import cpr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  cmd_t         cmd,
    output back_status_t status,
    output logic         res_valid,
    input  logic         res_pop,
    output result_t      res
);

    back_state_t st_reg, st_next;
    logic [ROW_W-1:0]   clr_reg, clr_next;
    cmd_t               cur_reg;
    logic [BLOCK_W-1:0] xfer_reg;
    logic [BLOCK_W-1:0] xfer_next;
    logic [BLOCK_W-1:0] rd_reg;
    logic [BLOCK_W-1:0] echo_reg [PORT_COUNT];
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg;

    logic [BLOCK_W-1:0] store_mem [ROWS];

    logic               mem_we;
    logic [ROW_W-1:0]   mem_addr;
    logic [BLOCK_W-1:0] mem_wdata;
    logic               take, crc_start, load, echo_we;
    logic               crc_done;
    logic [7:0]         crc_val;

    cpr_crc8 u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crc_start),
        .data  (xfer_next),
        .done  (crc_done),
        .crc   (crc_val)
    );

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        cmd_ready = 1'b0;
        take      = 1'b0;
        crc_start = 1'b0;
        load      = 1'b0;
        echo_we   = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = cmd.row;
        mem_wdata = cmd.data;

        // transferred bytes: write data, what the addressed block or echo cell holds, or zeros
        if (cur_reg.write_op)
            xfer_next = cur_reg.data;
        else if (cur_reg.target == TGT_STORE)
            xfer_next = rd_reg;
        else if (cur_reg.target == TGT_ECHO)
            xfer_next = echo_reg[cur_reg.port[ECHO_W-1:0]];
        else
            xfer_next = '0;

        case (st_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ROW_W'(ROWS - 1))
                    st_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    take    = 1'b1;
                    mem_we  = cmd.write_op && (cmd.target == TGT_STORE);
                    st_next = BK_ACCESS;
                end
            end
            BK_ACCESS:
            begin
                crc_start = 1'b1;
                echo_we   = cur_reg.write_op && (cur_reg.target == TGT_ECHO);
                st_next   = BK_CRC;
            end
            BK_CRC:
            begin
                if (crc_done)
                    st_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    load    = 1'b1;
                    st_next = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase

        res_valid_next = load ? 1'b1 : (res_pop ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
                echo_reg[p] <= '0;
        end
        else if (echo_we)
        begin
            echo_reg[cur_reg.port[ECHO_W-1:0]] <= cur_reg.data;
        end
    end

    // save store, one row per block
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        rd_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= cmd;
        if (crc_start)
            xfer_reg <= xfer_next;
        if (load)
        begin
            res_reg.port          <= cur_reg.port;
            res_reg.rdata         <= cur_reg.write_op ? '0 : xfer_reg;
            res_reg.crc           <= crc_val;
            res_reg.rumble_update <= (cur_reg.target == TGT_RUMBLE);
            res_reg.rumble_on     <= cur_reg.rumble_on;
        end
    end

    assign status.clearing = (st_reg == BK_CLEAR);
    assign res_valid       = res_valid_reg;
    assign res             = res_reg;

    a_clear_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_CLEAR) |-> !cmd_ready)
        else $error("command taken during store clear");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> res_valid_reg)
        else $error("result load lost");

    a_rumble_on_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.rumble_on) |-> res_reg.rumble_update)
        else $error("rumble state without update");

    a_crc_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        crc_start |=> (st_reg == BK_CRC))
        else $error("sequencer left CRC wait early");

endmodule

// File: src/controller_pak_responder_core.sv
// Channel   | Handshake              | Beat contents
// ----------+------------------------+-----------------------------------------------
// request   | push / full            | opcode, port, pak_address, write_data_0..3
// reply     | pop / empty            | reply_port, read_data_0..3, data_crc, rumble_*
//
// A transaction steps the back end through take (store read registered at
// that edge), CRC start, 33 byte-serial CRC steps (the last one the zero tail),
// done detect and reply load; the next command is taken only after that load.
// The CRC unit sets the rate. After reset the save store is swept to zero, one
// 256-bit row a cycle, PORT_COUNT * DATA_BLOCKS (4096) rows, with full high.
// A two-beat command queue takes requests while a reply waits; the back end
// stalls only while the reply register is still full.
module controller_pak_responder_core import cpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [1:0]  port,
    input  logic [15:0] pak_address,
    input  logic [63:0] write_data_0,
    input  logic [63:0] write_data_1,
    input  logic [63:0] write_data_2,
    input  logic [63:0] write_data_3,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  reply_port,
    output logic [63:0] read_data_0,
    output logic [63:0] read_data_1,
    output logic [63:0] read_data_2,
    output logic [63:0] read_data_3,
    output logic [7:0]  data_crc,
    output logic        rumble_update,
    output logic        rumble_on
);

    // front/back link
    cmd_t         cmd;
    logic         cmd_valid;
    logic         cmd_ready;
    back_status_t status;

    // reply register
    logic    res_valid;
    logic    res_pop;
    result_t res;

    // classify and queue requests
    cpr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .port         (port),
        .pak_address  (pak_address),
        .write_data_0 (write_data_0),
        .write_data_1 (write_data_1),
        .write_data_2 (write_data_2),
        .write_data_3 (write_data_3),
        .status       (status),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // store access, echo cells, CRC and reply
    cpr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_pop   (res_pop),
        .res       (res)
    );

    assign empty   = !res_valid;
    assign res_pop = pop && res_valid;

    assign reply_port    = res.port;
    assign read_data_0   = res.rdata[4*WORD_W-1 -: WORD_W];
    assign read_data_1   = res.rdata[3*WORD_W-1 -: WORD_W];
    assign read_data_2   = res.rdata[2*WORD_W-1 -: WORD_W];
    assign read_data_3   = res.rdata[WORD_W-1 -: WORD_W];
    assign data_crc      = res.crc;
    assign rumble_update = res.rumble_update;
    assign rumble_on     = res.rumble_on;

endmodule

// File: tb/sv/pak_reply_checker.sv
`timescale 1ns / 1ps

module pak_reply_checker import cpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        opcode,
    input  logic [1:0]  port,
    input  logic [15:0] pak_address,
    input  logic [63:0] write_data_0,
    input  logic [63:0] write_data_1,
    input  logic [63:0] write_data_2,
    input  logic [63:0] write_data_3,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  reply_port,
    input  logic [63:0] read_data_0,
    input  logic [63:0] read_data_1,
    input  logic [63:0] read_data_2,
    input  logic [63:0] read_data_3,
    input  logic [7:0]  data_crc,
    input  logic        rumble_update,
    input  logic        rumble_on,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]         port;
        logic [BLOCK_W-1:0] rdata;
        logic [7:0]         crc;
        logic               rumble_update;
        logic               rumble_on;
    } pak_reply_t;

    // shadow copies of the save store and echo cells, one block per row
    logic [BLOCK_W-1:0] save_rows [PORT_COUNT*DATA_BLOCKS];
    logic [BLOCK_W-1:0] echo_rows [PORT_COUNT];
    pak_reply_t         replies_due [$];
    int                 err_total;

    initial
    begin
        foreach (save_rows[i])
            save_rows[i] = '0;
        foreach (echo_rows[i])
            echo_rows[i] = '0;
        err_total = 0;
    end

    // bit-serial CRC-8, MSB first, eight zero bits flushed at the end
    function automatic logic [7:0] block_crc8(input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W+7:0] stream;
        logic [7:0]         acc;
        logic               top;
        stream = {blk, 8'h00};
        acc    = 8'h00;
        for (int i = BLOCK_W + 7; i >= 0; i--)
        begin
            top = acc[7];
            acc = {acc[6:0], stream[i]};
            if (top)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    function automatic pak_reply_t predict_reply(input logic write_op, input logic [1:0] p,
                                                 input logic [15:0] addr,
                                                 input logic [BLOCK_W-1:0] wdata);
        pak_reply_t         rep;
        logic [10:0]        blk;
        logic [BLOCK_W-1:0] moved;
        int                 row;
        blk      = addr[15:5];
        moved    = write_op ? wdata : '0;
        rep      = '0;
        rep.port = p;
        if (p < PORT_COUNT)
        begin
            if (blk == ECHO_BLOCK)
            begin
                if (write_op)
                    echo_rows[p] = moved;
                else
                    moved = echo_rows[p];
            end
            else if (blk < DATA_BLOCKS)
            begin
                row = p * DATA_BLOCKS + blk;
                if (write_op)
                    save_rows[row] = moved;
                else
                    moved = save_rows[row];
            end
            else if (blk == RUMBLE_BLOCK && write_op)
            begin
                rep.rumble_update = 1'b1;
                rep.rumble_on     = (moved[BLOCK_W-1 -: 8] != 8'h00);
            end
        end
        if (!write_op)
            rep.rdata = moved;
        rep.crc = block_crc8(moved);
        return rep;
    endfunction

    task automatic note_error(input string msg);
        err_total++;
        if (err_total <= 10)
            $display("[%0t] reply mismatch: %s", $time, msg);
    endtask

    task automatic check_reply(input pak_reply_t got);
        pak_reply_t want;
        if (replies_due.size() == 0)
        begin
            note_error($sformatf("reply for port %0d with nothing outstanding", got.port));
            return;
        end
        want = replies_due.pop_front();
        if (got.port !== want.port)
            note_error($sformatf("reply_port exp %0d got %0d", want.port, got.port));
        for (int w = 0; w < 4; w++)
            if (got.rdata[BLOCK_W-1-64*w -: 64] !== want.rdata[BLOCK_W-1-64*w -: 64])
                note_error($sformatf("read_data_%0d exp %h got %h", w,
                                     want.rdata[BLOCK_W-1-64*w -: 64],
                                     got.rdata[BLOCK_W-1-64*w -: 64]));
        if (got.crc !== want.crc)
            note_error($sformatf("data_crc exp %h got %h", want.crc, got.crc));
        if (got.rumble_update !== want.rumble_update)
            note_error($sformatf("rumble_update exp %b got %b",
                                 want.rumble_update, got.rumble_update));
        if (got.rumble_on !== want.rumble_on)
            note_error($sformatf("rumble_on exp %b got %b", want.rumble_on, got.rumble_on));
    endtask

    // requests are predicted before replies are matched; a reply can never
    // belong to a request taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                replies_due.push_back(predict_reply(opcode == OP_WRITE, port, pak_address,
                    {write_data_0, write_data_1, write_data_2, write_data_3}));
            if (pop && !empty)
                check_reply({reply_port, read_data_0, read_data_1, read_data_2, read_data_3,
                             data_crc, rumble_update, rumble_on});
        end
        mismatches  <= err_total;
        outstanding <= replies_due.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cpr_pkg::*;

    localparam int RANDOM_BEATS = 1430;
    // covers the post-reset clear sweep, then each beat's transaction plus
    // sender gaps and reply stalls
    localparam int CYCLE_LIMIT  = 600000;
    // extra wait after the last reply to catch stray replies
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         port;
        logic [15:0]        addr;
        logic [BLOCK_W-1:0] wdata;
    } pak_req_t;

    // reply-side ready patterns
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SLOW,
        DRAIN_PERIODIC
    } drain_mode_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        push         = 1'b0;
    logic        opcode       = OP_READ;
    logic [1:0]  port         = '0;
    logic [15:0] pak_address  = '0;
    logic [63:0] write_data_0 = '0;
    logic [63:0] write_data_1 = '0;
    logic [63:0] write_data_2 = '0;
    logic [63:0] write_data_3 = '0;
    logic        pop          = 1'b0;

    logic        full;
    logic        empty;
    logic [1:0]  reply_port;
    logic [63:0] read_data_0;
    logic [63:0] read_data_1;
    logic [63:0] read_data_2;
    logic [63:0] read_data_3;
    logic [7:0]  data_crc;
    logic        rumble_update;
    logic        rumble_on;

    int          mismatches;
    int          outstanding;
    int          cycle_count  = 0;
    drain_mode_t drain_mode   = DRAIN_FREE;
    int          drain_left   = 0;

    controller_pak_responder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .port          (port),
        .pak_address   (pak_address),
        .write_data_0  (write_data_0),
        .write_data_1  (write_data_1),
        .write_data_2  (write_data_2),
        .write_data_3  (write_data_3),
        .empty         (empty),
        .pop           (pop),
        .reply_port    (reply_port),
        .read_data_0   (read_data_0),
        .read_data_1   (read_data_1),
        .read_data_2   (read_data_2),
        .read_data_3   (read_data_3),
        .data_crc      (data_crc),
        .rumble_update (rumble_update),
        .rumble_on     (rumble_on)
    );

    pak_reply_checker reply_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .port          (port),
        .pak_address   (pak_address),
        .write_data_0  (write_data_0),
        .write_data_1  (write_data_1),
        .write_data_2  (write_data_2),
        .write_data_3  (write_data_3),
        .empty         (empty),
        .pop           (pop),
        .reply_port    (reply_port),
        .read_data_0   (read_data_0),
        .read_data_1   (read_data_1),
        .read_data_2   (read_data_2),
        .read_data_3   (read_data_3),
        .data_crc      (data_crc),
        .rumble_update (rumble_update),
        .rumble_on     (rumble_on),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs (full stuck high, reply never shows).
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Reply side: pop follows one ready pattern for a random stretch, then
    // switches. Free-running stretches let the command queue drain; the slow
    // and periodic ones back the reply register up so the block has to stall.
    always @(posedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode <= drain_mode_t'($urandom_range(0, 3));
            drain_left <= $urandom_range(16, 160);
            pop        <= 1'b1;
        end
        else
        begin
            drain_left <= drain_left - 1;
            case (drain_mode)
                DRAIN_FREE:     pop <= 1'b1;
                DRAIN_COIN:     pop <= 1'($urandom_range(0, 1));
                DRAIN_SLOW:     pop <= ($urandom_range(0, 5) == 0);
                default:        pop <= (drain_left[1:0] == 2'b00);
            endcase
        end
    end

    function automatic pak_req_t make_req(input logic op, input logic [1:0] p,
                                          input logic [10:0] blk, input logic [4:0] offset,
                                          input logic [BLOCK_W-1:0] data);
        pak_req_t r;
        r.opcode = op;
        r.port   = p;
        r.addr   = {blk, offset};
        r.wdata  = data;
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] random_block();
        logic [BLOCK_W-1:0] d;
        d = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            2: d[BLOCK_W-1 -: 8] = 8'h00;                       // rumble off, rest busy
            3: d = {8'($urandom_range(1, 255)), {(BLOCK_W-8){1'b0}}}; // rumble on alone
            default: ;
        endcase
        return d;
    endfunction

    // Random transaction. Nearly half hit a handful of save blocks per port so that
    // reads come back with data written earlier; the rest go to the echo
    // cell, the rumble block, any save block, or a fully random address.
    function automatic pak_req_t random_req();
        pak_req_t    r;
        int          pick;
        logic [10:0] blk;
        pick     = $urandom_range(0, 99);
        r.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        r.port   = 2'($urandom_range(0, 3));
        r.wdata  = random_block();
        if (pick < 45)
            blk = $urandom_range(0, 1) ? 11'($urandom_range(0, 7))
                                       : 11'(DATA_BLOCKS - 1 - $urandom_range(0, 7));
        else if (pick < 55)
            blk = 11'($urandom_range(0, DATA_BLOCKS - 1));
        else if (pick < 72)
            blk = ECHO_BLOCK;
        else if (pick < 85)
            blk = RUMBLE_BLOCK;
        else
            blk = 11'($urandom_range(0, 2047));
        r.addr = {blk, 5'($urandom_range(0, 31))};
        return r;
    endfunction

    // Present one beat and hold it until the block takes it. push is left
    // high; the caller lowers it only when a gap follows.
    task automatic send_beat(input pak_req_t r);
        opcode       <= r.opcode;
        port         <= r.port;
        pak_address  <= r.addr;
        write_data_0 <= r.wdata[255:192];
        write_data_1 <= r.wdata[191:128];
        write_data_2 <= r.wdata[127:64];
        write_data_3 <= r.wdata[63:0];
        push         <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    initial
    begin
        logic [BLOCK_W-1:0] ones;
        logic [BLOCK_W-1:0] mixed;
        logic [BLOCK_W-1:0] lead_zero;
        logic [BLOCK_W-1:0] lead_only;
        int                 sent;
        int                 burst;
        int                 gap;

        ones      = '1;
        mixed     = {64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                     64'hA5A5A5A55A5A5A5A, 64'h0F1E2D3C4B5A6978};
        lead_zero = {8'h00, {(BLOCK_W-8){1'b1}}};
        lead_only = {8'h01, {(BLOCK_W-8){1'b0}}};
        sent      = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats, back to back. full stays up through the post-reset
        // clear sweep, so the first one simply waits for it.
        send_beat(make_req(OP_READ,  2'd0, 11'd0, 5'd0, '0));          // cleared store
        send_beat(make_req(OP_WRITE, 2'd0, 11'd0, 5'd0, ones));
        send_beat(make_req(OP_READ,  2'd0, 11'd0, 5'd31, '0));         // low bits ignored
        send_beat(make_req(OP_WRITE, 2'd3, 11'(DATA_BLOCKS - 1), 5'd31, mixed));
        send_beat(make_req(OP_READ,  2'd3, 11'(DATA_BLOCKS - 1), 5'd0, ones)); // data ignored
        send_beat(make_req(OP_READ,  2'd2, 11'(DATA_BLOCKS - 1), 5'd0, '0));   // other port
        send_beat(make_req(OP_WRITE, 2'd1, ECHO_BLOCK, 5'd0, mixed));
        send_beat(make_req(OP_READ,  2'd1, ECHO_BLOCK, 5'd31, '0));
        send_beat(make_req(OP_READ,  2'd2, ECHO_BLOCK, 5'd0, '0));    // untouched echo
        send_beat(make_req(OP_WRITE, 2'd0, RUMBLE_BLOCK, 5'd0, lead_only));  // motor on
        send_beat(make_req(OP_WRITE, 2'd0, RUMBLE_BLOCK, 5'd31, lead_zero)); // motor off
        send_beat(make_req(OP_READ,  2'd0, RUMBLE_BLOCK, 5'd0, ones));  // rumble read: zeros
        send_beat(make_req(OP_WRITE, 2'd2, ECHO_BLOCK + 11'd1, 5'd0, ones)); // dropped
        send_beat(make_req(OP_READ,  2'd2, ECHO_BLOCK + 11'd1, 5'd0, '0));
        send_beat(make_req(OP_WRITE, 2'd1, 11'h7FF, 5'd31, ones));     // top of address space
        send_beat(make_req(OP_READ,  2'd1, 11'h7FF, 5'd31, '0));
        send_beat(make_req(OP_WRITE, 2'd1, RUMBLE_BLOCK - 11'd1, 5'd0, ones));
        send_beat(make_req(OP_WRITE, 2'd3, RUMBLE_BLOCK + 11'd1, 5'd0, ones)); // no rumble
        send_beat(make_req(OP_WRITE, 2'd2, 11'd1, 5'd0, '0));
        send_beat(make_req(OP_READ,  2'd0, 11'd0, 5'd0, '0));
        send_beat(make_req(OP_WRITE, 2'd3, RUMBLE_BLOCK, 5'd0, ones));

        // Random part: bursts of varying length with gaps between, a quarter
        // of them with no gap at all so long back-to-back runs occur too.
        while (sent < RANDOM_BEATS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                send_beat(random_req());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;

        // wait for an edge so the checker's count includes the last beat taken
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
